@@ hw/rtl/touch_gesture_classifier_unit_defines.svh @@
// ---------------------------------------------------------------------------
// Touch gesture classifier assertion macros
// Shared concurrent assertion forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef TOUCH_GESTURE_CLASSIFIER_UNIT_DEFINES_SVH
`define TOUCH_GESTURE_CLASSIFIER_UNIT_DEFINES_SVH

// Checked on every rising clock edge outside reset.
`define TGC_ASSERT_RUN(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("touch gesture classifier check failed");

// Checked on every rising clock edge, reset included.
`define TGC_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("touch gesture classifier reset check failed");

`endif

@@ hw/rtl/tgc_pkg.sv @@
// ---------------------------------------------------------------------------
// Touch gesture classifier package
// Widths, codes, configuration types and small helper functions.
// ---------------------------------------------------------------------------
package tgc_pkg;

   localparam int COORD_BITS     = 8;
   localparam int CFG_BITS       = 8;
   localparam int HELD_BITS      = 8;
   localparam int GESTURE_BITS   = 3;
   localparam int LINK_BITS      = 2;
   localparam int CSR_INDEX_BITS = 3;
   localparam int SQ_BITS        = 2 * COORD_BITS;

   localparam logic [HELD_BITS-1:0] HELD_MAX = {HELD_BITS{1'b1}};

   typedef enum logic [GESTURE_BITS-1:0] {
      GESTURE_NONE       = 3'd0,
      GESTURE_NEXT       = 3'd1,
      GESTURE_PREV       = 3'd2,
      GESTURE_SETTINGS   = 3'd3,
      GESTURE_FAIL_RESET = 3'd4,
      GESTURE_LONG_RESET = 3'd5
   } gesture_type;

   typedef enum logic [LINK_BITS-1:0] {
      LINK_OTHER     = 2'd0,
      LINK_CONNECTED = 2'd1,
      LINK_FAILED    = 2'd2,
      LINK_UNUSED    = 2'd3
   } link_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SWIPE_TRAVEL      = 3'd0,
      CSR_TAP_MAX           = 3'd1,
      CSR_LONG_PRESS_FRAMES = 3'd2,
      CSR_TAP_FRAMES_MAX    = 3'd3,
      CSR_BUTTON_CX         = 3'd4,
      CSR_BUTTON_CY         = 3'd5,
      CSR_BUTTON_RADIUS     = 3'd6,
      CSR_RESERVED          = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] swipe_travel;
      logic [CFG_BITS-1:0] tap_max;
      logic [CFG_BITS-1:0] long_press_frames;
      logic [CFG_BITS-1:0] tap_frames_max;
      logic [CFG_BITS-1:0] button_cx;
      logic [CFG_BITS-1:0] button_cy;
      logic [SQ_BITS-1:0]  radius_sq;
   } cfg_type;

   localparam logic [CFG_BITS-1:0] RESET_SWIPE_TRAVEL      = 8'd40;
   localparam logic [CFG_BITS-1:0] RESET_TAP_MAX           = 8'd15;
   localparam logic [CFG_BITS-1:0] RESET_LONG_PRESS_FRAMES = 8'd30;
   localparam logic [CFG_BITS-1:0] RESET_TAP_FRAMES_MAX    = 8'd10;
   localparam logic [CFG_BITS-1:0] RESET_BUTTON_CX         = 8'd120;
   localparam logic [CFG_BITS-1:0] RESET_BUTTON_CY         = 8'd210;
   localparam logic [CFG_BITS-1:0] RESET_BUTTON_RADIUS     = 8'd30;

   function automatic logic [COORD_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                      input logic [COORD_BITS-1:0] b);
      return (a >= b) ? (a - b) : (b - a);
   endfunction

endpackage

@@ hw/rtl/tgc_channels.sv @@
// ---------------------------------------------------------------------------
// Touch gesture classifier channels
// Valid/ready channel interfaces for samples, results and register writes.
// ---------------------------------------------------------------------------
interface tgc_req_if;
   import tgc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  sample_ok;
   logic                  pressed;
   logic [COORD_BITS-1:0] touch_x;
   logic [COORD_BITS-1:0] touch_y;
   logic                  on_clock_view;
   logic [LINK_BITS-1:0]  link_state;

   modport source (output valid, sample_ok, pressed, touch_x, touch_y, on_clock_view,
                   link_state, input ready);
   modport sink   (input valid, sample_ok, pressed, touch_x, touch_y, on_clock_view,
                   link_state, output ready);
endinterface

interface tgc_rsp_if;
   import tgc_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [GESTURE_BITS-1:0] gesture;
   logic                    is_touching;

   modport source (output valid, gesture, is_touching, input ready);
   modport sink   (input valid, gesture, is_touching, output ready);
endinterface

interface tgc_csr_if;
   import tgc_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CFG_BITS-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/tgc_cfg.sv @@
// ---------------------------------------------------------------------------
// Touch gesture classifier configuration registers
// Holds six tuning registers and the squared button radius.
// ---------------------------------------------------------------------------
module tgc_cfg (
   input  logic             clock,
   input  logic             reset,
   tgc_csr_if.sink          csr_if,
   output tgc_pkg::cfg_type cfg
);
   import tgc_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   logic          wr_en;
   csr_index_type wr_index;

   assign csr_if.ready = 1'b1;
   assign wr_en        = csr_if.valid;
   assign wr_index     = csr_index_type'(csr_if.index);

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_SWIPE_TRAVEL:      cfg_in.swipe_travel      = csr_if.data;
            CSR_TAP_MAX:           cfg_in.tap_max           = csr_if.data;
            CSR_LONG_PRESS_FRAMES: cfg_in.long_press_frames = csr_if.data;
            CSR_TAP_FRAMES_MAX:    cfg_in.tap_frames_max    = csr_if.data;
            CSR_BUTTON_CX:         cfg_in.button_cx         = csr_if.data;
            CSR_BUTTON_CY:         cfg_in.button_cy         = csr_if.data;
            CSR_BUTTON_RADIUS:     cfg_in.radius_sq         = SQ_BITS'(csr_if.data)
                                                              * SQ_BITS'(csr_if.data);
            CSR_RESERVED:          cfg_in = cfg_ff;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.swipe_travel      <= RESET_SWIPE_TRAVEL;
         cfg_ff.tap_max           <= RESET_TAP_MAX;
         cfg_ff.long_press_frames <= RESET_LONG_PRESS_FRAMES;
         cfg_ff.tap_frames_max    <= RESET_TAP_FRAMES_MAX;
         cfg_ff.button_cx         <= RESET_BUTTON_CX;
         cfg_ff.button_cy         <= RESET_BUTTON_CY;
         cfg_ff.radius_sq         <= SQ_BITS'(RESET_BUTTON_RADIUS)
                                     * SQ_BITS'(RESET_BUTTON_RADIUS);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hw/rtl/touch_gesture_classifier_unit.sv @@
// ---------------------------------------------------------------------------
// Touch gesture classifier unit
// Turns polled touch samples into swipe, tap and long press events.
// ---------------------------------------------------------------------------
// Every accepted sample gives exactly one result, in order, through the sample
// register and the result register. The block takes one sample per clock while
// the result side does not stall: a sample register feeds one stage of compare
// logic and a squared distance test against the button, which updates the
// contact state and loads the result register in the same cycle. Register
// writes take effect on the next cycle.
module touch_gesture_classifier_unit (
   input logic     clock,
   input logic     reset,
   tgc_req_if.sink req_if,
   tgc_rsp_if.source rsp_if,
   tgc_csr_if.sink csr_if
);
   import tgc_pkg::*;

   cfg_type cfg;

   tgc_cfg u_cfg (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_ok_ff, s1_pressed_ff, s1_clock_ff;
   logic [COORD_BITS-1:0] s1_x_ff, s1_y_ff;
   link_type              s1_link_ff;

   logic                  touching_ff, touching_in;
   logic [COORD_BITS-1:0] start_x_ff, start_x_in, start_y_ff, start_y_in;
   logic [COORD_BITS-1:0] last_x_ff, last_x_in, last_y_ff, last_y_in;
   logic [HELD_BITS-1:0]  held_ff, held_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   gesture_type           gesture_ff, gesture_in;
   logic                  is_touching_ff;

   logic                  out_advance, req_xfer, step;
   logic                  new_contact;
   logic [COORD_BITS-1:0] btn_x, btn_y, bdx, bdy;
   logic [SQ_BITS-1:0]    bdx_sq, bdy_sq;
   logic [SQ_BITS:0]      dist_sq;
   logic                  in_button;
   logic [HELD_BITS-1:0]  held_base;
   logic                  held_step;
   logic [COORD_BITS-1:0] adx, ady;
   logic [COORD_BITS:0]   ady_x2;

   assign out_advance  = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = !s1_valid_ff || out_advance;
   assign req_xfer     = req_if.valid && req_if.ready;
   assign step         = s1_valid_ff && out_advance;

   assign s1_valid_in = req_xfer ? 1'b1 : (out_advance ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_ok_ff      <= req_if.sample_ok;
         s1_pressed_ff <= req_if.pressed;
         s1_x_ff       <= req_if.touch_x;
         s1_y_ff       <= req_if.touch_y;
         s1_clock_ff   <= req_if.on_clock_view;
         s1_link_ff    <= link_type'(req_if.link_state);
      end
   end

   // The button test always looks at the start of the contact.
   assign new_contact = s1_ok_ff && s1_pressed_ff && !touching_ff;
   assign btn_x       = new_contact ? s1_x_ff : start_x_ff;
   assign btn_y       = new_contact ? s1_y_ff : start_y_ff;
   assign bdx         = abs_diff(btn_x, cfg.button_cx);
   assign bdy         = abs_diff(btn_y, cfg.button_cy);
   assign bdx_sq      = SQ_BITS'(bdx) * SQ_BITS'(bdx);
   assign bdy_sq      = SQ_BITS'(bdy) * SQ_BITS'(bdy);
   assign dist_sq     = {1'b0, bdx_sq} + {1'b0, bdy_sq};
   assign in_button   = dist_sq <= {1'b0, cfg.radius_sq};

   assign held_base = touching_ff ? held_ff : '0;
   assign held_step = held_base != HELD_MAX;

   always_comb begin
      if (s1_ok_ff && s1_pressed_ff) begin
         adx = abs_diff(s1_x_ff, btn_x);
         ady = abs_diff(s1_y_ff, btn_y);
      end else begin
         adx = abs_diff(last_x_ff, start_x_ff);
         ady = abs_diff(last_y_ff, start_y_ff);
      end
      ady_x2 = {ady, 1'b0};
   end

   always_comb begin
      touching_in = touching_ff;
      start_x_in  = start_x_ff;
      start_y_in  = start_y_ff;
      last_x_in   = last_x_ff;
      last_y_in   = last_y_ff;
      held_in     = held_ff;
      gesture_in  = GESTURE_NONE;
      priority if (s1_ok_ff && s1_pressed_ff) begin
         touching_in = 1'b1;
         start_x_in  = btn_x;
         start_y_in  = btn_y;
         last_x_in   = s1_x_ff;
         last_y_in   = s1_y_ff;
         held_in     = held_step ? held_base + HELD_BITS'(1) : held_base;
         if (held_step && (held_in == cfg.long_press_frames) && s1_clock_ff && in_button
             && (adx < cfg.tap_max) && (ady < cfg.tap_max)) begin
            gesture_in = GESTURE_LONG_RESET;
         end
      end else if (s1_ok_ff && touching_ff) begin
         touching_in = 1'b0;
         priority if (({1'b0, adx} > {1'b0, cfg.swipe_travel}) && ({1'b0, adx} > ady_x2)) begin
            gesture_in = (last_x_ff < start_x_ff) ? GESTURE_NEXT : GESTURE_PREV;
         end else if ((adx < cfg.tap_max) && (ady < cfg.tap_max)
                      && (held_ff < cfg.tap_frames_max)) begin
            priority if ((s1_link_ff == LINK_CONNECTED) && s1_clock_ff && in_button) begin
               gesture_in = GESTURE_SETTINGS;
            end else if (s1_link_ff == LINK_FAILED) begin
               gesture_in = GESTURE_FAIL_RESET;
            end else begin
               gesture_in = GESTURE_NONE;
            end
         end else begin
            gesture_in = GESTURE_NONE;
         end
      end else begin
         gesture_in = GESTURE_NONE;
      end
   end

   assign rsp_valid_in = step ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         touching_ff  <= 1'b0;
         start_x_ff   <= '0;
         start_y_ff   <= '0;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         held_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            touching_ff <= touching_in;
            start_x_ff  <= start_x_in;
            start_y_ff  <= start_y_in;
            last_x_ff   <= last_x_in;
            last_y_ff   <= last_y_in;
            held_ff     <= held_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         gesture_ff     <= gesture_in;
         is_touching_ff <= touching_in;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.gesture     = gesture_ff;
   assign rsp_if.is_touching = is_touching_ff;

endmodule

@@ hw/rtl/tgc_checker.sv @@
// ---------------------------------------------------------------------------
// Touch gesture classifier port checker
// Checks result channel behavior seen at the top-level ports.
// ---------------------------------------------------------------------------
`include "touch_gesture_classifier_unit_defines.svh"

module tgc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [tgc_pkg::GESTURE_BITS-1:0] rsp_gesture,
   input logic                             rsp_is_touching
);
   import tgc_pkg::*;

   logic release_event;

   assign release_event = (rsp_gesture == GESTURE_NEXT) || (rsp_gesture == GESTURE_PREV)
                          || (rsp_gesture == GESTURE_SETTINGS)
                          || (rsp_gesture == GESTURE_FAIL_RESET);

   `TGC_ASSERT_ALWAYS(a_idle_after_reset, $past(reset) |-> !rsp_valid)
   `TGC_ASSERT_RUN(a_rsp_held, rsp_valid && !rsp_ready |=> rsp_valid)
   `TGC_ASSERT_RUN(a_gesture_code, rsp_valid |-> rsp_gesture <= GESTURE_LONG_RESET)
   `TGC_ASSERT_RUN(a_release_clears, rsp_valid && release_event |-> !rsp_is_touching)
   `TGC_ASSERT_RUN(a_long_press_held, rsp_valid && rsp_gesture == GESTURE_LONG_RESET |-> rsp_is_touching)

endmodule

bind touch_gesture_classifier_unit tgc_checker u_tgc_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_gesture     (rsp_if.gesture),
   .rsp_is_touching (rsp_if.is_touching)
);

@@ tb/sv/touch_gesture_classifier_unit_tb.sv @@
// ---------------------------------------------------------------------------
// Touch gesture classifier unit testbench
// Drives touch samples through the sample channel under random burst gaps and
// result-side stalls, and writes the button and threshold registers between
// phases. A scoreboard tracks the contact state, predicts the gesture and the
// touching flag for every accepted sample, and compares each result transfer
// in order.
// ---------------------------------------------------------------------------
module touch_gesture_classifier_unit_tb;
   import tgc_pkg::*;

   typedef struct packed {
      logic                  sample_ok;
      logic                  pressed;
      logic [COORD_BITS-1:0] touch_x;
      logic [COORD_BITS-1:0] touch_y;
      logic                  on_clock_view;
      link_type              link_state;
   } touch_sample_type;

   typedef struct {
      gesture_type gesture;
      logic        is_touching;
   } touch_event_type;

   class gesture_scoreboard;
      logic [CFG_BITS-1:0]   swipe_travel;
      logic [CFG_BITS-1:0]   tap_max;
      logic [CFG_BITS-1:0]   long_press_frames;
      logic [CFG_BITS-1:0]   tap_frames_max;
      logic [CFG_BITS-1:0]   button_cx;
      logic [CFG_BITS-1:0]   button_cy;
      logic [CFG_BITS-1:0]   button_radius;
      logic                  touching;
      logic [COORD_BITS-1:0] start_x;
      logic [COORD_BITS-1:0] start_y;
      logic [COORD_BITS-1:0] last_x;
      logic [COORD_BITS-1:0] last_y;
      logic [HELD_BITS-1:0]  held_frames;
      touch_event_type       expected_events[$];
      int                    events_checked;
      int                    mismatches;

      function new();
         swipe_travel      = RESET_SWIPE_TRAVEL;
         tap_max           = RESET_TAP_MAX;
         long_press_frames = RESET_LONG_PRESS_FRAMES;
         tap_frames_max    = RESET_TAP_FRAMES_MAX;
         button_cx         = RESET_BUTTON_CX;
         button_cy         = RESET_BUTTON_CY;
         button_radius     = RESET_BUTTON_RADIUS;
         touching          = 1'b0;
         start_x           = '0;
         start_y           = '0;
         last_x            = '0;
         last_y            = '0;
         held_frames       = '0;
         events_checked    = 0;
         mismatches        = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CFG_BITS-1:0] value);
         case (idx)
            CSR_SWIPE_TRAVEL:      swipe_travel = value;
            CSR_TAP_MAX:           tap_max = value;
            CSR_LONG_PRESS_FRAMES: long_press_frames = value;
            CSR_TAP_FRAMES_MAX:    tap_frames_max = value;
            CSR_BUTTON_CX:         button_cx = value;
            CSR_BUTTON_CY:         button_cy = value;
            CSR_BUTTON_RADIUS:     button_radius = value;
            default: ;
         endcase
      endfunction

      function int travel(logic [COORD_BITS-1:0] a, logic [COORD_BITS-1:0] b);
         return (a >= b) ? int'(a) - int'(b) : int'(b) - int'(a);
      endfunction

      function bit on_button(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y);
         int dx;
         int dy;
         dx = int'(x) - int'(button_cx);
         dy = int'(y) - int'(button_cy);
         return dx * dx + dy * dy <= int'(button_radius) * int'(button_radius);
      endfunction

      function void note_sample(touch_sample_type s);
         gesture_type          g;
         logic [HELD_BITS-1:0] prior;
         int                   adx;
         int                   ady;
         touch_event_type      ev;
         g = GESTURE_NONE;
         if (s.sample_ok) begin
            if (s.pressed) begin
               if (!touching) begin
                  start_x     = s.touch_x;
                  start_y     = s.touch_y;
                  held_frames = '0;
                  touching    = 1'b1;
               end
               last_x = s.touch_x;
               last_y = s.touch_y;
               prior  = held_frames;
               if (held_frames != HELD_MAX)
                  held_frames = held_frames + HELD_BITS'(1);
               if (held_frames != prior && held_frames == long_press_frames
                   && s.on_clock_view && on_button(start_x, start_y)
                   && travel(last_x, start_x) < int'(tap_max)
                   && travel(last_y, start_y) < int'(tap_max))
                  g = GESTURE_LONG_RESET;
            end else if (touching) begin
               adx      = travel(last_x, start_x);
               ady      = travel(last_y, start_y);
               touching = 1'b0;
               if (adx > int'(swipe_travel) && adx > 2 * ady) begin
                  g = (last_x < start_x) ? GESTURE_NEXT : GESTURE_PREV;
               end else if (adx < int'(tap_max) && ady < int'(tap_max)
                            && held_frames < tap_frames_max) begin
                  if (s.link_state == LINK_CONNECTED && s.on_clock_view
                      && on_button(start_x, start_y))
                     g = GESTURE_SETTINGS;
                  else if (s.link_state == LINK_FAILED)
                     g = GESTURE_FAIL_RESET;
               end
            end
         end
         ev.gesture     = g;
         ev.is_touching = touching;
         expected_events.push_back(ev);
      endfunction

      task report(string what);
         $display("%0t: %s", $time, what);
         mismatches++;
      endtask

      task check_event(logic [GESTURE_BITS-1:0] g, logic t);
         touch_event_type want;
         events_checked++;
         if (expected_events.size() == 0) begin
            report($sformatf("result with no sample pending: gesture %0d touching %0b", g, t));
            return;
         end
         want = expected_events.pop_front();
         if (g !== want.gesture)
            report($sformatf("gesture %0d, expected %0d", g, want.gesture));
         if (t !== want.is_touching)
            report($sformatf("touching flag %0b, expected %0b", t, want.is_touching));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   tgc_req_if req_bus ();
   tgc_rsp_if rsp_bus ();
   tgc_csr_if csr_bus ();

   touch_gesture_classifier_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   gesture_scoreboard board = new();

   int items_sent    = 0;
   int burst_left    = 0;
   bit gaps_on       = 1'b0;
   bit hold_off_req  = 1'b0;

   always #4 clock = ~clock;

   always @(posedge clock) begin
      touch_sample_type s;
      if (reset === 1'b0) begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            board.check_event(rsp_bus.gesture, rsp_bus.is_touching);
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
            s.sample_ok     = req_bus.sample_ok;
            s.pressed       = req_bus.pressed;
            s.touch_x       = req_bus.touch_x;
            s.touch_y       = req_bus.touch_y;
            s.on_clock_view = req_bus.on_clock_view;
            s.link_state    = link_type'(req_bus.link_state);
            board.note_sample(s);
         end
      end
   end

   initial begin
      int stall_left;
      int cyc;
      stall_left = 0;
      cyc = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         cyc++;
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            stall_left = 150;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case ((cyc / 40) % 4)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               2: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_bus.ready <= cyc[1];
            endcase
         end
      end
   end

   initial begin
      #(8 * 400000);
      $display("Mismatches found");
      $finish;
   end

   function automatic logic [COORD_BITS-1:0] clamp_coord(int v);
      if (v < 0)
         return '0;
      if (v > 255)
         return '1;
      return v[COORD_BITS-1:0];
   endfunction

   task automatic send_sample(touch_sample_type s);
      if (gaps_on && burst_left <= 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_bus.valid         <= 1'b1;
      req_bus.sample_ok     <= s.sample_ok;
      req_bus.pressed       <= s.pressed;
      req_bus.touch_x       <= s.touch_x;
      req_bus.touch_y       <= s.touch_y;
      req_bus.on_clock_view <= s.on_clock_view;
      req_bus.link_state    <= s.link_state;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      items_sent++;
   endtask

   task automatic send(bit ok, bit pr, int x, int y, bit view, link_type link);
      touch_sample_type s;
      s.sample_ok     = ok;
      s.pressed       = pr;
      s.touch_x       = clamp_coord(x);
      s.touch_y       = clamp_coord(y);
      s.on_clock_view = view;
      s.link_state    = link;
      send_sample(s);
   endtask

   task automatic send_noise(bit ok);
      send(ok, 1'($urandom_range(0, 1)), $urandom_range(0, 255), $urandom_range(0, 255),
           1'($urandom_range(0, 1)), link_type'($urandom_range(0, 3)));
   endtask

   task automatic touch_contact(int x0, int y0, int x1, int y1, int frames, bit view,
                                link_type link, bit noisy);
      int div;
      div = (frames > 1) ? frames - 1 : 1;
      for (int i = 0; i < frames; i++) begin
         send(1'b1, 1'b1, x0 + (x1 - x0) * i / div, y0 + (y1 - y0) * i / div, view, link);
         if (noisy && $urandom_range(0, 3) == 0)
            send_noise(1'b0);
      end
      send(1'b1, 1'b0, $urandom_range(0, 255), $urandom_range(0, 255), view, link);
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (board.events_checked < items_sent) @(posedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [CFG_BITS-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      board.write_reg(idx, value);
   endtask

   task automatic apply_settings(logic [CFG_BITS-1:0] swipe, logic [CFG_BITS-1:0] tap,
                                 logic [CFG_BITS-1:0] long_frames,
                                 logic [CFG_BITS-1:0] tap_frames,
                                 logic [CFG_BITS-1:0] cx, logic [CFG_BITS-1:0] cy,
                                 logic [CFG_BITS-1:0] radius);
      csr_write(CSR_SWIPE_TRAVEL, swipe);
      csr_write(CSR_TAP_MAX, tap);
      csr_write(CSR_LONG_PRESS_FRAMES, long_frames);
      csr_write(CSR_TAP_FRAMES_MAX, tap_frames);
      csr_write(CSR_RESERVED, CFG_BITS'($urandom_range(0, 255)));
      csr_write(CSR_BUTTON_CX, cx);
      csr_write(CSR_BUTTON_CY, cy);
      csr_write(CSR_BUTTON_RADIUS, radius);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic random_gestures(int budget);
      int first;
      int kind;
      int r;
      int m;
      int lo;
      int mag;
      int frames;
      int sx;
      int sy;
      int ex;
      int ey;
      first = items_sent;
      while (items_sent - first < budget) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         kind = $urandom_range(0, 9);
         r = int'(board.button_radius);
         m = (int'(board.tap_max) < 20) ? int'(board.tap_max) : 20;
         sx = int'(board.button_cx) + int'($urandom_range(0, 2 * r + 10)) - (r + 5);
         sy = int'(board.button_cy) + int'($urandom_range(0, 2 * r + 10)) - (r + 5);
         ex = sx + int'($urandom_range(0, 2 * m)) - m;
         ey = sy + int'($urandom_range(0, 2 * m)) - m;
         lo = (int'(board.tap_frames_max) < 11) ? int'(board.tap_frames_max) + 1 : 12;
         frames = $urandom_range(1, lo);
         if (kind <= 2) begin
            lo = (int'(board.swipe_travel) > 10) ? int'(board.swipe_travel) - 10 : 0;
            mag = $urandom_range(lo, 255);
            sx = $urandom_range(0, 255);
            sy = $urandom_range(0, 255);
            ex = ($urandom_range(0, 1) != 0) ? sx + mag : sx - mag;
            ey = sy + int'($urandom_range(0, mag / 2 + 4)) - (mag / 4 + 2);
            frames = $urandom_range(2, 6);
         end else if (kind <= 5) begin
         end else if (kind <= 7) begin
            if (int'(board.long_press_frames) <= 40)
               frames = int'(board.long_press_frames) + int'($urandom_range(0, 3));
         end
         if (kind >= 8) begin
            repeat ($urandom_range(1, 5)) send_noise($urandom_range(0, 3) != 0);
         end else begin
            touch_contact(sx, sy, ex, ey, frames, $urandom_range(0, 3) != 0,
                          link_type'($urandom_range(0, 3)), $urandom_range(0, 4) == 0);
         end
      end
   endtask

   initial begin
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.sample_ok     <= 1'b0;
      req_bus.pressed       <= 1'b0;
      req_bus.touch_x       <= '0;
      req_bus.touch_y       <= '0;
      req_bus.on_clock_view <= 1'b0;
      req_bus.link_state    <= LINK_OTHER;
      csr_bus.valid         <= 1'b0;
      csr_bus.index         <= CSR_SWIPE_TRAVEL;
      csr_bus.data          <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send(1'b0, 1'b1, 255, 255, 1'b1, LINK_FAILED);
      send(1'b1, 1'b0, 0, 0, 1'b1, LINK_FAILED);
      touch_contact(120, 210, 122, 211, 2, 1'b1, LINK_CONNECTED, 1'b0);
      touch_contact(0, 0, 0, 0, 1, 1'b0, LINK_FAILED, 1'b0);
      touch_contact(121, 209, 121, 209, 1, 1'b1, LINK_OTHER, 1'b0);
      touch_contact(120, 210, 120, 210, 1, 1'b1, LINK_UNUSED, 1'b0);
      touch_contact(200, 40, 100, 45, 3, 1'b1, LINK_CONNECTED, 1'b0);
      touch_contact(0, 255, 255, 250, 2, 1'b0, LINK_FAILED, 1'b0);
      touch_contact(130, 200, 131, 201, 3, 1'b1, LINK_CONNECTED, 1'b1);
      random_gestures(25);
      wait_idle();

      apply_settings(8'd0, 8'd255, 8'd1, 8'd255, 8'd0, 8'd0, 8'd255);
      touch_contact(5, 5, 5, 5, 3, 1'b1, LINK_OTHER, 1'b0);
      gaps_on = 1'b0;
      hold_off_req = 1'b1;
      repeat (8) begin
         touch_contact($urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(0, 255), 3, 1'b1,
                       link_type'($urandom_range(0, 3)), 1'b0);
      end
      random_gestures(15);
      wait_idle();

      apply_settings(8'd255, 8'd1, 8'd254, 8'd1, 8'd255, 8'd255, 8'd0);
      gaps_on = 1'b1;
      touch_contact(255, 255, 255, 255, 258, 1'b1, LINK_CONNECTED, 1'b0);
      touch_contact(255, 255, 255, 255, 1, 1'b1, LINK_FAILED, 1'b0);
      random_gestures(10);
      wait_idle();

      apply_settings(CFG_BITS'($urandom_range(0, 120)), 8'd0,
                     CFG_BITS'($urandom_range(1, 40)), CFG_BITS'($urandom_range(1, 40)),
                     CFG_BITS'($urandom_range(0, 255)), CFG_BITS'($urandom_range(0, 255)),
                     CFG_BITS'($urandom_range(0, 255)));
      random_gestures(20);
      wait_idle();

      apply_settings(RESET_SWIPE_TRAVEL, RESET_TAP_MAX, RESET_LONG_PRESS_FRAMES,
                     RESET_TAP_FRAMES_MAX, RESET_BUTTON_CX, RESET_BUTTON_CY,
                     RESET_BUTTON_RADIUS);
      random_gestures(20);
      wait_idle();

      repeat (6) @(posedge clock);
      if (board.expected_events.size() != 0)
         board.report($sformatf("%0d results never arrived", board.expected_events.size()));
      if (board.mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
